@@ src/qvp_pkg.sv @@
// ============================================================================
// qvp_pkg
// Shared types and constants for the quaternion vertex projection pipeline.
// ============================================================================
`default_nettype none

package qvp_pkg;

    // Screen size defaults
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // Register indexes on the configuration channel
    typedef enum logic [3:0] {
        REG_QUAT_W   = 4'd0,
        REG_QUAT_X   = 4'd1,
        REG_QUAT_Y   = 4'd2,
        REG_QUAT_Z   = 4'd3,
        REG_CAM_X    = 4'd4,
        REG_CAM_Y    = 4'd5,
        REG_CAM_H    = 4'd6,
        REG_FOCAL    = 4'd7
    } t_reg_idx;

    // Reset values
    localparam logic signed [15:0] QUAT_W_RST = 16'sd16384;
    localparam logic [13:0]        CAM_H_RST  = 14'd3891;
    localparam logic [9:0]         FOCAL_RST  = 10'd280;

    // Camera height clamp, Q4.10 (2.4 .. 8.0)
    localparam logic [13:0] CAM_H_MIN = 14'd2458;
    localparam logic [13:0] CAM_H_MAX = 14'd8192;

    // Divider: quotient bits kept before saturation takes over
    localparam int DIV_STEPS = 18;

    // Start strobe to result strobe, in clock edges
    localparam int PIPE_LAT = DIV_STEPS + 6;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               visible;
    } t_result;

    // Per-item sideband carried through the divider stages
    typedef struct packed {
        logic vis;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } t_tag;

endpackage

`default_nettype wire

@@ src/quaternion_vertex_project.sv @@
// ============================================================================
// quaternion_vertex_project
// Rotates a model-space vertex by a unit quaternion and projects it to screen.
// ============================================================================
//
// Usage
//   Vertex channel: drive i_vertex and pulse start; the vertex transaction is
//   taken at any edge where start is high and busy is low. busy is high only
//   during reset and the cycle after it, so one vertex can enter every clock.
//   Result channel: o_strobe is high for exactly one cycle with o_result.
//   Each vertex gives one result, in order. The receiver cannot hold
//   results off, and none is needed: the pipeline never stalls.
//   Config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; o_cfg_ready is always high. Unknown indexes are dropped;
//   camera height is clamped to 2.4..8.0. Write only while no vertex is in
//   flight.
//   Throughput is one vertex per clock. Four stages of quaternion matrix,
//   rotation, translation and scaling come first, then the divider: an
//   overflow check plus one quotient bit per stage (18 stages), then an
//   output register.
//   Reset (synchronous, active low) restores the register defaults and
//   clears every pipeline valid bit; items in flight are dropped.
// ============================================================================
`default_nettype none

module quaternion_vertex_project
    import qvp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_vertex     i_vertex,
    output logic             o_strobe,
    output t_result          o_result,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int NW = 62;   // numerator |c| * f
    localparam int DW = 52;   // depth magnitude
    localparam int CW = 71;   // compare width for shifted divisor
    localparam int SW = 22;   // offset + quotient before saturation
    localparam logic signed [SW-1:0] OFF_X = SW'(SCREEN_WIDTH / 2);
    localparam logic signed [SW-1:0] OFF_Y = SW'(SCREEN_HEIGHT / 2);
    localparam logic signed [34:0]   ONE28 = 35'sd1 <<< 28;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] r_quat_w, r_quat_x, r_quat_y, r_quat_z;
    logic signed [15:0] r_cam_x, r_cam_y;
    logic [13:0]        r_cam_h;
    logic [9:0]         r_focal;
    logic [13:0]        n_cam_h;
    logic               r_busy;
    logic               cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign busy        = r_busy;

    always_comb begin
        if (i_cfg_data[13:0] < CAM_H_MIN) begin
            n_cam_h = CAM_H_MIN;
        end else if (i_cfg_data[13:0] > CAM_H_MAX) begin
            n_cam_h = CAM_H_MAX;
        end else begin
            n_cam_h = i_cfg_data[13:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_w <= QUAT_W_RST;
            r_quat_x <= '0;
            r_quat_y <= '0;
            r_quat_z <= '0;
            r_cam_x  <= '0;
            r_cam_y  <= '0;
            r_cam_h  <= CAM_H_RST;
            r_focal  <= FOCAL_RST;
            r_busy   <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (cfg_we) begin
                unique case (i_cfg_index)
                    REG_QUAT_W: r_quat_w <= i_cfg_data;
                    REG_QUAT_X: r_quat_x <= i_cfg_data;
                    REG_QUAT_Y: r_quat_y <= i_cfg_data;
                    REG_QUAT_Z: r_quat_z <= i_cfg_data;
                    REG_CAM_X:  r_cam_x  <= i_cfg_data;
                    REG_CAM_Y:  r_cam_y  <= i_cfg_data;
                    REG_CAM_H:  r_cam_h  <= n_cam_h;
                    REG_FOCAL:  r_focal  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: rotation matrix in Q28 from the quaternion
    // ------------------------------------------------------------------
    logic signed [31:0] aa, bb, cc, ab, ac, bc, wa, wb, wc;
    logic signed [34:0] n_m [9];
    logic signed [34:0] r_m [9];
    logic               r_v1;
    t_vertex            r_vtx1;

    always_comb begin
        aa = r_quat_x * r_quat_x;
        bb = r_quat_y * r_quat_y;
        cc = r_quat_z * r_quat_z;
        ab = r_quat_x * r_quat_y;
        ac = r_quat_x * r_quat_z;
        bc = r_quat_y * r_quat_z;
        wa = r_quat_w * r_quat_x;
        wb = r_quat_w * r_quat_y;
        wc = r_quat_w * r_quat_z;
        // transposed, with the mount flip folded in: rows are (r0j, r1j, -r2j)
        n_m[0] = ONE28 - ((35'(bb) + 35'(cc)) <<< 1);   // r00
        n_m[1] = (35'(ab) + 35'(wc)) <<< 1;             // r10
        n_m[2] = -((35'(ac) - 35'(wb)) <<< 1);          // -r20
        n_m[3] = (35'(ab) - 35'(wc)) <<< 1;             // r01
        n_m[4] = ONE28 - ((35'(aa) + 35'(cc)) <<< 1);   // r11
        n_m[5] = -((35'(bc) + 35'(wa)) <<< 1);          // -r21
        n_m[6] = (35'(ac) + 35'(wb)) <<< 1;             // r02
        n_m[7] = (35'(bc) - 35'(wa)) <<< 1;             // r12
        n_m[8] = -(ONE28 - ((35'(aa) + 35'(bb)) <<< 1)); // -r22
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_vtx1 <= i_vertex;
    end

    // ------------------------------------------------------------------
    // Stage 2: nine matrix-vector products, Q38
    // ------------------------------------------------------------------
    logic signed [50:0] r_p [9];
    logic               r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_p[3*i]   <= r_m[3*i]   * r_vtx1.vertex_x;
            r_p[3*i+1] <= r_m[3*i+1] * r_vtx1.vertex_y;
            r_p[3*i+2] <= r_m[3*i+2] * r_vtx1.vertex_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums and camera translation
    // ------------------------------------------------------------------
    logic signed [52:0] n_rx, n_ry, n_rz;
    logic signed [52:0] r_cx, r_cy, r_dz;
    logic               r_v3;

    assign n_rx = 53'(r_p[0]) + 53'(r_p[1]) + 53'(r_p[2]);
    assign n_ry = 53'(r_p[3]) + 53'(r_p[4]) + 53'(r_p[5]);
    assign n_rz = 53'(r_p[6]) + 53'(r_p[7]) + 53'(r_p[8]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx <= n_rx - (53'(r_cam_x) <<< 28);
        r_cy <= n_ry - (53'(r_cam_y) <<< 28);
        r_dz <= (53'($signed({1'b0, r_cam_h})) <<< 28) - n_rz;
    end

    // ------------------------------------------------------------------
    // Stage 4: near test, magnitudes, focal scaling
    // ------------------------------------------------------------------
    logic [52:0]   abs_cx, abs_cy;
    logic [NW-1:0] r_num_x4, r_num_y4;
    logic [DW-1:0] r_den4;
    t_tag          r_tag4;
    logic          r_v4;

    assign abs_cx = r_cx[52] ? 53'(-r_cx) : 53'(r_cx);
    assign abs_cy = r_cy[52] ? 53'(-r_cy) : 53'(r_cy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num_x4     <= abs_cx[DW-1:0] * r_focal;
        r_num_y4     <= abs_cy[DW-1:0] * r_focal;
        r_den4       <= r_dz[DW-1:0];
        // exact test 10*depth >= 1.0 in Q38
        r_tag4.vis   <= (57'(r_dz) * 57'sd10) >= (57'sd1 <<< 38);
        r_tag4.neg_x <= r_cx[52];
        r_tag4.neg_y <= r_cy[52];
        r_tag4.ovf_x <= 1'b0;
        r_tag4.ovf_y <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Divider: stage 0 checks quotient overflow, then one bit per stage
    // ------------------------------------------------------------------
    logic [NW-1:0]        r_rem_x [DIV_STEPS+1];
    logic [NW-1:0]        r_rem_y [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q_x   [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q_y   [DIV_STEPS+1];
    logic [DW-1:0]        r_den   [DIV_STEPS+1];
    t_tag                 r_tag   [DIV_STEPS+1];
    logic [DIV_STEPS:0]   r_dv;
    logic [CW-1:0]        den_top;
    t_tag                 n_tag0;

    assign den_top = CW'(r_den4) << DIV_STEPS;

    always_comb begin
        n_tag0       = r_tag4;
        n_tag0.ovf_x = CW'(r_num_x4) >= den_top;
        n_tag0.ovf_y = CW'(r_num_y4) >= den_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem_x[0]       <= r_num_x4;
        r_rem_y[0]       <= r_num_y4;
        r_q_x[0]         <= '0;
        r_q_y[0]         <= '0;
        r_den[0]         <= r_den4;
        r_tag[0]         <= n_tag0;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int K = DIV_STEPS - 1 - j;
        logic [CW-1:0]        dsh;
        logic                 ge_x, ge_y;
        logic [DIV_STEPS-1:0] q_nx, q_ny;

        assign dsh  = CW'(r_den[j]) << K;
        assign ge_x = CW'(r_rem_x[j]) >= dsh;
        assign ge_y = CW'(r_rem_y[j]) >= dsh;

        always_comb begin
            q_nx    = r_q_x[j];
            q_ny    = r_q_y[j];
            q_nx[K] = ge_x;
            q_ny[K] = ge_y;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else begin
                r_dv[j+1] <= r_dv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem_x[j+1]    <= ge_x ? NW'(CW'(r_rem_x[j]) - dsh) : r_rem_x[j];
            r_rem_y[j+1]    <= ge_y ? NW'(CW'(r_rem_y[j]) - dsh) : r_rem_y[j];
            r_q_x[j+1]      <= q_nx;
            r_q_y[j+1]      <= q_ny;
            r_den[j+1]      <= r_den[j];
            r_tag[j+1]      <= r_tag[j];
        end
    end

    // ------------------------------------------------------------------
    // Output: hidden-vertex zeroing, screen offset, sign, saturation
    // ------------------------------------------------------------------
    t_tag                 t_fin;
    logic [DIV_STEPS-1:0] qx, qy;
    logic signed [SW-1:0] sx, sy;
    t_result              n_res;
    t_result              r_res;
    logic                 r_strobe;

    function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
        logic signed [15:0] s;
        if (v > SW'(32767)) begin
            s = 16'sh7FFF;
        end else if (v < -SW'(32768)) begin
            s = -16'sh8000;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

    always_comb begin
        t_fin = r_tag[DIV_STEPS];
        qx    = t_fin.ovf_x ? '1 : r_q_x[DIV_STEPS];
        qy    = t_fin.ovf_y ? '1 : r_q_y[DIV_STEPS];
        sx    = t_fin.neg_x ? OFF_X - SW'(qx) : OFF_X + SW'(qx);
        sy    = t_fin.neg_y ? OFF_Y + SW'(qy) : OFF_Y - SW'(qy);
        if (t_fin.vis) begin
            n_res.screen_x = sat16(sx);
            n_res.screen_y = sat16(sy);
            n_res.visible  = 1'b1;
        end else begin
            n_res = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_dv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

`default_nettype wire

@@ src/qvp_check.sv @@
// ============================================================================
// qvp_check
// Port-level checks for the vertex projection pipeline.
// ============================================================================
`default_nettype none

module qvp_check
    import qvp_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_strobe,
    input wire t_result o_result
);

    // every result traces back to a vertex transaction a fixed latency earlier
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, PIPE_LAT))
        else $error("result without matching vertex transaction");

    // every vertex transaction yields a result after the fixed latency
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_strobe)
        else $error("vertex transaction produced no result");

    // hidden vertices report a zero position
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.visible) |->
            (o_result.screen_x == 16'sd0 && o_result.screen_y == 16'sd0))
        else $error("hidden vertex with nonzero position");

    // busy drops in the cycle after reset and stays low
    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy high outside reset recovery");

endmodule

bind quaternion_vertex_project qvp_check u_qvp_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

@@ tb/sv/quaternion_vertex_project_tb.sv @@
// ============================================================================
// quaternion_vertex_project_tb
// Self-checking bench: streams vertices through the projection pipeline under
// several quaternion / camera / focal settings and compares every result
// against an exact integer projection computed in the bench.
// ============================================================================
`timescale 1ns / 100ps

module quaternion_vertex_project_tb;
    import qvp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_vertex     i_vertex;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    quaternion_vertex_project uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy), .i_vertex(i_vertex),
        .o_strobe(o_strobe), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Bench copy of the configuration registers
    logic signed [15:0] q_w, q_x, q_y, q_z, cam_x, cam_y;
    logic [13:0]        cam_h;
    logic [9:0]         focal;

    t_vertex vertex_q[$];       // vertices waiting for the driver
    t_result projected_q[$];    // expected results, oldest first
    int      err_count;
    int      sent_count;
    bit      quiet_stretch;     // no idling while set

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Exact integer projection: rotation in Q28, coordinates in Q38
    function automatic t_result project_vertex(input t_vertex v);
        longint one28, w, a, b, c, vx, vy, vz;
        longint r00, r01, r02, r10, r11, r12, r20, r21, r22;
        longint rx, ry, rz, tx, ty, depth, px, py;
        t_result r;
        one28 = longint'(1) << 28;
        w = q_w; a = q_x; b = q_y; c = q_z;
        vx = v.vertex_x; vy = v.vertex_y; vz = v.vertex_z;
        r00 = one28 - 2 * (b * b + c * c);
        r01 = 2 * (a * b - w * c);
        r02 = 2 * (a * c + w * b);
        r10 = 2 * (a * b + w * c);
        r11 = one28 - 2 * (a * a + c * c);
        r12 = 2 * (b * c - w * a);
        r20 = 2 * (a * c - w * b);
        r21 = 2 * (b * c + w * a);
        r22 = one28 - 2 * (a * a + b * b);
        // mount flip negates the z row before the transpose
        rx = r00 * vx + r10 * vy - r20 * vz;
        ry = r01 * vx + r11 * vy - r21 * vz;
        rz = r02 * vx + r12 * vy - r22 * vz;
        tx = rx - longint'(cam_x) * one28;
        ty = ry - longint'(cam_y) * one28;
        depth = longint'({1'b0, cam_h}) * one28 - rz;
        r = '0;
        if (depth * 10 < (longint'(1) << 38))
            return r;   // behind the near plane
        px = 160 + (tx * longint'({1'b0, focal})) / depth;
        py = 120 - (ty * longint'({1'b0, focal})) / depth;
        if (px > 32767) px = 32767;
        if (px < -32768) px = -32768;
        if (py > 32767) py = 32767;
        if (py < -32768) py = -32768;
        r.screen_x = px[15:0];
        r.screen_y = py[15:0];
        r.visible  = 1'b1;
        return r;
    endfunction

    // Vertex driver: pops the next pending vertex; idles at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                projected_q.push_back(project_vertex(i_vertex));
                sent_count++;
            end
            if (!(start && busy)) begin
                if (vertex_q.size() > 0 && (quiet_stretch || $urandom_range(99) >= 18)) begin
                    i_vertex <= vertex_q.pop_front();
                    start    <= 1'b1;
                end else begin
                    start    <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (projected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                exp_r = projected_q.pop_front();
                if (o_result.visible !== exp_r.visible)
                    report_mismatch($sformatf("visible got %0b exp %0b",
                        o_result.visible, exp_r.visible));
                if (o_result.screen_x !== exp_r.screen_x)
                    report_mismatch($sformatf("screen_x got %0d exp %0d",
                        o_result.screen_x, exp_r.screen_x));
                if (o_result.screen_y !== exp_r.screen_y)
                    report_mismatch($sformatf("screen_y got %0d exp %0d",
                        o_result.screen_y, exp_r.screen_y));
            end
        end
    end

    // One config transaction; mirrors the write into the bench registers
    task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
        logic [13:0] h;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_QUAT_W: q_w   = data;
            REG_QUAT_X: q_x   = data;
            REG_QUAT_Y: q_y   = data;
            REG_QUAT_Z: q_z   = data;
            REG_CAM_X:  cam_x = data;
            REG_CAM_Y:  cam_y = data;
            REG_CAM_H: begin
                h = data[13:0];
                if (h < CAM_H_MIN) h = CAM_H_MIN;
                if (h > CAM_H_MAX) h = CAM_H_MAX;
                cam_h = h;
            end
            REG_FOCAL:  focal = data[9:0];
            default: ;
        endcase
    endtask

    // Wait for the pipeline to drain
    task automatic drain();
        while (vertex_q.size() > 0 || start || projected_q.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic push_vertex(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        t_vertex v;
        v.vertex_x = x; v.vertex_y = y; v.vertex_z = z;
        vertex_q.push_back(v);
    endtask

    // Random vertex; mostly near the origin so many land on screen
    task automatic push_random_vertex();
        logic [15:0] x, y, z;
        if ($urandom_range(3) == 0) begin
            x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end else begin
            x = 16'($urandom_range(0, 8191) - 4096);
            y = 16'($urandom_range(0, 8191) - 4096);
            z = 16'($urandom_range(0, 8191) - 4096);
        end
        push_vertex(x, y, z);
    endtask

    // Random setting: quaternion components in -1.0..1.0, camera and focal
    task automatic write_random_setting();
        write_reg(REG_QUAT_W, 16'($urandom_range(0, 32768) - 16384));
        write_reg(REG_QUAT_X, 16'($urandom_range(0, 32768) - 16384));
        write_reg(REG_QUAT_Y, 16'($urandom_range(0, 32768) - 16384));
        write_reg(REG_QUAT_Z, 16'($urandom_range(0, 32768) - 16384));
        write_reg(REG_CAM_X, 16'($urandom_range(0, 4095) - 2048));
        write_reg(REG_CAM_Y, 16'($urandom));
        write_reg(REG_CAM_H, 16'($urandom));
        write_reg(REG_FOCAL, 16'($urandom));
    endtask

    initial begin
        err_count     = 0;
        sent_count    = 0;
        quiet_stretch = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_vertex      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        q_w = QUAT_W_RST; q_x = 0; q_y = 0; q_z = 0;
        cam_x = 0; cam_y = 0; cam_h = CAM_H_RST; focal = FOCAL_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, field extremes, near plane
        push_vertex(16'h0000, 16'h0000, 16'h0000);
        push_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_vertex(16'h8000, 16'h8000, 16'h8000);
        push_vertex(16'h7FFF, 16'h8000, 16'h0000);
        push_vertex(16'h0000, 16'h0000, -16'sd3789);   // depth just below 0.1 (flip)
        push_vertex(16'h0000, 16'h0000, 16'd3789);
        push_vertex(16'h0000, 16'h0000, 16'd3788);
        push_vertex(16'h0000, 16'h0000, 16'd3790);
        push_vertex(16'h0400, 16'hFC00, 16'h0000);
        push_vertex(16'h5555, 16'hAAAA, 16'h5555);
        drain();

        // Clamp extremes, zero focal, non-unit quaternion
        write_reg(REG_CAM_H, 16'h0000);
        write_reg(REG_FOCAL, 16'h0000);
        write_reg(4'd9, 16'h1234);          // unknown index, dropped
        push_vertex(16'h0400, 16'h0400, 16'h0000);
        push_vertex(16'h8000, 16'h7FFF, 16'h0000);
        drain();
        write_reg(REG_CAM_H, 16'hFFFF);
        write_reg(REG_FOCAL, 16'h03FF);
        write_reg(REG_QUAT_W, 16'h8000);
        write_reg(REG_QUAT_X, 16'h4000);
        write_reg(REG_QUAT_Y, 16'hC000);
        write_reg(REG_QUAT_Z, 16'h7FFF);
        write_reg(REG_CAM_X, 16'h7FFF);
        write_reg(REG_CAM_Y, 16'h8000);
        push_vertex(16'h7FFF, 16'h0000, 16'h8000);
        push_vertex(16'h8000, 16'h7FFF, 16'h7FFF);
        push_vertex(16'h0000, 16'h0000, 16'h0000);
        push_vertex(16'h1000, 16'hF000, 16'h0800);
        drain();

        // Random phases, each under a fresh setting
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 0) begin
                write_reg(REG_QUAT_W, QUAT_W_RST);
                write_reg(REG_QUAT_X, 16'h0000);
                write_reg(REG_QUAT_Y, 16'h0000);
                write_reg(REG_QUAT_Z, 16'h0000);
                write_reg(REG_CAM_X, 16'h0000);
                write_reg(REG_CAM_Y, 16'h0000);
                write_reg(REG_CAM_H, 16'(CAM_H_RST));
                write_reg(REG_FOCAL, 16'(FOCAL_RST));
            end else begin
                write_random_setting();
            end
            quiet_stretch = (ph == 4);
            for (int i = 0; i < 150; i++)
                push_random_vertex();
            drain();
        end
        quiet_stretch = 1'b0;

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
